// ===== hw/rtl/gbct_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gbct_pkg
// Shared types and constants of the group-by count table: request and
// response payloads, table sizes, and the controller/datapath interface.
// -----------------------------------------------------------------------------
package gbct_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 64;
   localparam int COUNT_BITS = 32;
   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int USED_BITS  = $clog2(CAPACITY + 1);

   localparam int ROW_KEY_W     = 64;
   localparam int GROUP_KEY_W   = 64;
   localparam int GROUP_COUNT_W = 32;

   localparam logic OP_COUNT = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef struct packed {
      logic                 op;
      logic [ROW_KEY_W-1:0] row_key;
      logic                 row_selected;
   } req_type;

   typedef struct packed {
      logic [GROUP_KEY_W-1:0]   group_key;
      logic [GROUP_COUNT_W-1:0] group_count;
      logic                     group_present;
      logic                     group_last;
      logic                     groups_dropped;
   } rsp_type;

   typedef struct packed {
      logic load_key;
      logic clear_idx;
      logic inc_idx;
      logic rd;
      logic write_hit;
      logic alloc;
      logic emit_entry;
      logic emit_empty;
      logic clear_table;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic used_zero;
      logic idx_last;
   } status_type;

endpackage

// ===== hw/rtl/gbct_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gbct_ctrl
// Controller of the group-by count table. Sequences the linear key search,
// entry allocation and the drain sweep, one request at a time.
// -----------------------------------------------------------------------------
module gbct_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_op,
   input  logic                   req_selected,
   input  gbct_pkg::status_type   status,
   output gbct_pkg::cmd_type      cmd,
   output logic                   busy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CMP,
      ST_ALLOC,
      ST_DRAIN_READ,
      ST_DRAIN_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_op == gbct_pkg::OP_DRAIN) begin
                  if (status.used_zero) begin
                     cmd.emit_empty  = 1'b1;
                     cmd.clear_table = 1'b1;
                  end else begin
                     cmd.clear_idx = 1'b1;
                     state_in      = ST_DRAIN_READ;
                  end
               end else if (req_selected) begin
                  cmd.load_key  = 1'b1;
                  cmd.clear_idx = 1'b1;
                  state_in      = status.used_zero ? ST_ALLOC : ST_READ;
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.hit) begin
               cmd.write_hit = 1'b1;
               state_in      = ST_IDLE;
            end else if (status.idx_last) begin
               state_in = ST_ALLOC;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_DRAIN_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_DRAIN_EMIT;
         end
         ST_DRAIN_EMIT: begin
            cmd.emit_entry = 1'b1;
            if (status.idx_last) begin
               cmd.clear_table = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_DRAIN_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ===== hw/rtl/gbct_datapath.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// gbct_datapath
// Datapath of the group-by count table: key and count memories, search
// index, fill count, dropped flag and the registered response.
// -----------------------------------------------------------------------------
module gbct_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [gbct_pkg::ROW_KEY_W-1:0] req_key,
   input  gbct_pkg::cmd_type              cmd,
   output gbct_pkg::status_type           status,
   output logic                           rsp_strobe,
   output gbct_pkg::rsp_type              rsp_item
);

   logic [gbct_pkg::KEY_BITS-1:0]   key_mem [gbct_pkg::CAPACITY];
   logic [gbct_pkg::COUNT_BITS-1:0] count_mem [gbct_pkg::CAPACITY];

   logic [gbct_pkg::KEY_BITS-1:0]   key_ff;
   logic [gbct_pkg::KEY_BITS-1:0]   key_rd_ff;
   logic [gbct_pkg::COUNT_BITS-1:0] count_rd_ff;
   logic [gbct_pkg::IDX_BITS-1:0]   idx_ff;
   logic [gbct_pkg::USED_BITS-1:0]  used_ff;
   logic                            dropped_ff;
   logic                            rsp_strobe_ff;
   gbct_pkg::rsp_type               rsp_item_ff;

   logic                            table_full;
   logic [gbct_pkg::COUNT_BITS-1:0] count_inc;
   logic [gbct_pkg::IDX_BITS-1:0]   alloc_addr;

   assign table_full = (used_ff == gbct_pkg::USED_BITS'(gbct_pkg::CAPACITY));
   assign count_inc  = (&count_rd_ff) ? count_rd_ff
                                      : count_rd_ff + gbct_pkg::COUNT_BITS'(1);
   assign alloc_addr = used_ff[gbct_pkg::IDX_BITS-1:0];

   assign status.hit       = (key_rd_ff == key_ff);
   assign status.used_zero = (used_ff == '0);
   assign status.idx_last  = ((gbct_pkg::USED_BITS'(idx_ff) + gbct_pkg::USED_BITS'(1))
                              == used_ff);

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         key_rd_ff   <= key_mem[idx_ff];
         count_rd_ff <= count_mem[idx_ff];
      end
      if (cmd.write_hit) begin
         count_mem[idx_ff] <= count_inc;
      end else if (cmd.alloc && !table_full) begin
         key_mem[alloc_addr]   <= key_ff;
         count_mem[alloc_addr] <= gbct_pkg::COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_key) begin
         key_ff <= req_key[gbct_pkg::KEY_BITS-1:0];
      end
      if (cmd.clear_idx) begin
         idx_ff <= '0;
      end else if (cmd.inc_idx) begin
         idx_ff <= idx_ff + gbct_pkg::IDX_BITS'(1);
      end
      if (cmd.emit_empty) begin
         rsp_item_ff.group_key      <= '0;
         rsp_item_ff.group_count    <= '0;
         rsp_item_ff.group_present  <= 1'b0;
         rsp_item_ff.group_last     <= 1'b1;
         rsp_item_ff.groups_dropped <= dropped_ff;
      end else if (cmd.emit_entry) begin
         rsp_item_ff.group_key      <= gbct_pkg::GROUP_KEY_W'(key_rd_ff);
         rsp_item_ff.group_count    <= gbct_pkg::GROUP_COUNT_W'(count_rd_ff);
         rsp_item_ff.group_present  <= 1'b1;
         rsp_item_ff.group_last     <= status.idx_last;
         rsp_item_ff.groups_dropped <= dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= '0;
         dropped_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit_entry | cmd.emit_empty;
         if (cmd.clear_table) begin
            used_ff    <= '0;
            dropped_ff <= 1'b0;
         end else if (cmd.alloc) begin
            if (table_full) begin
               dropped_ff <= 1'b1;
            end else begin
               used_ff <= used_ff + gbct_pkg::USED_BITS'(1);
            end
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   a_used_bounded: assert property (@(posedge clock) disable iff (reset)
      used_ff <= gbct_pkg::USED_BITS'(gbct_pkg::CAPACITY))
      else $error("Fill count exceeds table capacity.");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_table |=> (used_ff == '0) && !dropped_ff)
      else $error("Table not empty after a drain.");

   a_alloc_grows: assert property (@(posedge clock) disable iff (reset)
      (cmd.alloc && !table_full) |=>
         used_ff == $past(used_ff) + gbct_pkg::USED_BITS'(1))
      else $error("Allocation did not grow the table.");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_item_ff.group_present) |-> rsp_item_ff.group_last)
      else $error("Empty drain response is not marked last.");

   a_emit_one_source: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_entry && cmd.emit_empty))
      else $error("Two response sources in one cycle.");

endmodule

// ===== hw/rtl/group_by_count_table_core.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// group_by_count_table_core
// Group-by count engine: counts selected row keys per distinct key in a
// table of first appearance, and drains all groups on request.
// -----------------------------------------------------------------------------
//  Channel   Ports                    Handshake
//  request   start, busy, req_item    taken when start is high and busy is low
//  response  rsp_strobe, rsp_item     one cycle per response, cannot be stalled
//
// A count request on an empty table allocates the first entry; otherwise
// the entries are read and compared in order, the key memory having one
// read port and being searched one entry at a time. A hit increments that
// count; a miss after the last entry allocates one. An unselected row leaves
// the table as it is. A drain emits one response per entry, one on an empty table.
// Reset clears the fill count and the dropped flag; no clearing pass is needed.
// -----------------------------------------------------------------------------
module group_by_count_table_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gbct_pkg::req_type req_item,
   output logic              rsp_strobe,
   output gbct_pkg::rsp_type rsp_item
);

   gbct_pkg::cmd_type    cmd;
   gbct_pkg::status_type status;

   gbct_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_op       (req_item.op),
      .req_selected (req_item.row_selected),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy)
   );

   gbct_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_key    (req_item.row_key),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule
